[design/posting_list_gap_varint_encoder_defines.svh]
// Assertion macros for the posting-list gap encoder.
// Each use expects clk_i and rst_ni in scope.
`ifndef POSTING_LIST_GAP_VARINT_ENCODER_DEFINES_SVH
`define POSTING_LIST_GAP_VARINT_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that cond implies prop in the same cycle.
`define PLGVE_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Check that cond implies prop in the following cycle.
`define PLGVE_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`else

`define PLGVE_ASSERT_IMP(label, cond, prop, msg)
`define PLGVE_ASSERT_NXT(label, cond, prop, msg)

`endif

`endif

[design/plgve_pkg.sv]
package plgve_pkg;

  // Field widths
  localparam int unsigned FileIdBits  = 8;
  localparam int unsigned PrevBits    = 9;
  localparam int unsigned FillBits    = 25;
  localparam int unsigned OffsetBits  = 48;
  localparam int unsigned BaseBits    = 32;

  // Previous file id meaning "none yet" (minus one)
  localparam logic [PrevBits-1:0] PREV_NONE = 9'h1FF;

  // Input mode codes
  localparam logic MODE_ENTRY  = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // Register index (word address bit) of base_offset
  localparam logic REG_BASE_OFFSET = 1'b0;

  // Reset value of base_offset
  localparam logic [BaseBits-1:0] BASE_OFFSET_RESET = 32'd16;

  // Byte counts
  localparam logic [1:0] COUNT_NONE = 2'd0;
  localparam logic [1:0] COUNT_ONE  = 2'd1;
  localparam logic [1:0] COUNT_TWO  = 2'd2;

  // One result word
  typedef struct packed {
    logic [1:0]            byte_count;
    logic [7:0]            first_byte;
    logic [7:0]            second_byte;
    logic                  fill_valid;
    logic [FillBits-1:0]   fill_first;
    logic [FillBits-1:0]   fill_last;
    logic [OffsetBits-1:0] fill_offset;
  } result_t;

endpackage

[design/plgve_step.sv]
module plgve_step #(
  parameter int unsigned TrigramBits = 24
) (
  input  logic                                mode_i,
  input  logic [TrigramBits-1:0]              trigram_i,
  input  logic [plgve_pkg::FileIdBits-1:0]    file_id_i,
  input  logic [TrigramBits-1:0]              last_trigram_i,
  input  logic [plgve_pkg::PrevBits-1:0]      previous_file_i,
  input  logic [plgve_pkg::OffsetBits-1:0]    running_offset_i,
  input  logic [plgve_pkg::BaseBits-1:0]      base_offset_i,
  output plgve_pkg::result_t                  result_o,
  output logic [TrigramBits-1:0]              last_trigram_o,
  output logic [plgve_pkg::PrevBits-1:0]      previous_file_o,
  output logic [plgve_pkg::OffsetBits-1:0]    running_offset_o
);

  logic                               tri_change;
  logic [plgve_pkg::PrevBits-1:0]     prev_eff;
  logic                               negative;
  logic [plgve_pkg::PrevBits-1:0]     gap;
  logic [plgve_pkg::FillBits-1:0]     range_first;
  logic [plgve_pkg::FillBits-1:0]     table_end;

  // Compare trigrams and form the gap against the effective previous file
  assign tri_change  = (trigram_i != last_trigram_i);
  assign prev_eff    = tri_change ? plgve_pkg::PREV_NONE : previous_file_i;
  assign negative    = (prev_eff != plgve_pkg::PREV_NONE) &&
                       ({1'b0, file_id_i} <= prev_eff);
  assign gap         = {1'b0, file_id_i} - (prev_eff + 9'd1);
  assign range_first = plgve_pkg::FillBits'(last_trigram_i) + 25'd1;
  assign table_end   = 25'd1 << TrigramBits;

  // Encode one word and advance the state
  always_comb begin
    result_o             = '0;
    result_o.fill_offset = running_offset_i;
    last_trigram_o       = last_trigram_i;
    previous_file_o      = previous_file_i;
    running_offset_o     = running_offset_i;
    if (mode_i == plgve_pkg::MODE_FINISH) begin
      result_o.fill_valid = 1'b1;
      result_o.fill_first = range_first;
      result_o.fill_last  = table_end;
      last_trigram_o      = '0;
      previous_file_o     = plgve_pkg::PREV_NONE;
      running_offset_o    = plgve_pkg::OffsetBits'(base_offset_i);
    end else begin
      // Report the slot range only when the trigram goes up
      if (trigram_i > last_trigram_i) begin
        result_o.fill_valid = 1'b1;
        result_o.fill_first = range_first;
        result_o.fill_last  = plgve_pkg::FillBits'(trigram_i);
      end
      if (negative) begin
        result_o.byte_count = plgve_pkg::COUNT_ONE;
        result_o.first_byte = gap[7:0];
      end else if (gap[8:7] != 2'b00) begin
        result_o.byte_count  = plgve_pkg::COUNT_TWO;
        result_o.first_byte  = {1'b1, gap[6:0]};
        result_o.second_byte = {6'b0, gap[8:7]};
      end else begin
        result_o.byte_count = plgve_pkg::COUNT_ONE;
        result_o.first_byte = {1'b0, gap[6:0]};
      end
      last_trigram_o   = trigram_i;
      previous_file_o  = {1'b0, file_id_i};
      running_offset_o = running_offset_i + plgve_pkg::OffsetBits'(result_o.byte_count);
    end
  end

endmodule

[design/posting_list_gap_varint_encoder.sv]
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    mode_i, trigram_i, file_id_i
// result    out        out_valid_o / out_ready_i  byte_count_o .. fill_offset_o
// config    in         APB write (psel/penable)   paddr, pwdata -> base_offset
//
// One word per cycle sustained while out_ready_i stays high; an accepted word
// passes to the output through the input register, then the result register.
// The encode and state update sit between the input register and the result
// register; the running offset, last trigram and previous file update there.
// Reset clears the state to base_offset = 16, running offset = base_offset.
// When the output stalls, the result is held and one more word waits in the
// input register before in_ready_o drops.
`include "posting_list_gap_varint_encoder_defines.svh"

module posting_list_gap_varint_encoder #(
  parameter int unsigned TrigramBits = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [23:0]                       trigram_i,
  input  logic [plgve_pkg::FileIdBits-1:0]  file_id_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        byte_count_o,
  output logic [7:0]                        first_byte_o,
  output logic [7:0]                        second_byte_o,
  output logic                              fill_valid_o,
  output logic [plgve_pkg::FillBits-1:0]    fill_first_o,
  output logic [plgve_pkg::FillBits-1:0]    fill_last_o,
  output logic [plgve_pkg::OffsetBits-1:0]  fill_offset_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [plgve_pkg::BaseBits-1:0]    pwdata,
  output logic [plgve_pkg::BaseBits-1:0]    prdata,
  output logic                              pready
);

  // Input register
  logic                              s1_valid_q;
  logic                              s1_mode_q;
  logic [TrigramBits-1:0]            s1_trigram_q;
  logic [plgve_pkg::FileIdBits-1:0]  s1_file_id_q;
  logic                              s1_adv;
  logic                              in_acc;

  // Result register
  logic                              out_valid_q;
  plgve_pkg::result_t                res_q;
  plgve_pkg::result_t                res_d;

  // Encoder state
  logic [TrigramBits-1:0]            last_trigram_q, last_trigram_d;
  logic [plgve_pkg::PrevBits-1:0]    previous_file_q, previous_file_d;
  logic [plgve_pkg::OffsetBits-1:0]  running_offset_q, running_offset_d;
  logic                              started_q;
  logic [plgve_pkg::BaseBits-1:0]    base_offset_q;
  logic                              cfg_wr;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == plgve_pkg::REG_BASE_OFFSET);

  // Register read and ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == plgve_pkg::REG_BASE_OFFSET) ? base_offset_q : '0;

  plgve_step #(
    .TrigramBits (TrigramBits)
  ) u_step (
    .mode_i           (s1_mode_q),
    .trigram_i        (s1_trigram_q),
    .file_id_i        (s1_file_id_q),
    .last_trigram_i   (last_trigram_q),
    .previous_file_i  (previous_file_q),
    .running_offset_i (running_offset_q),
    .base_offset_i    (base_offset_q),
    .result_o         (res_d),
    .last_trigram_o   (last_trigram_d),
    .previous_file_o  (previous_file_d),
    .running_offset_o (running_offset_d)
  );

  // Track valid flags of both registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q    <= mode_i;
      s1_trigram_q <= trigram_i[TrigramBits-1:0];
      s1_file_id_q <= file_id_i;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  // Advance encoder state; config write loads base_offset, and the running offset while not started
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_trigram_q   <= '0;
      previous_file_q  <= plgve_pkg::PREV_NONE;
      running_offset_q <= plgve_pkg::OffsetBits'(plgve_pkg::BASE_OFFSET_RESET);
      started_q        <= 1'b0;
      base_offset_q    <= plgve_pkg::BASE_OFFSET_RESET;
    end else begin
      if (cfg_wr) begin
        base_offset_q <= pwdata;
      end
      if (s1_adv) begin
        last_trigram_q   <= last_trigram_d;
        previous_file_q  <= previous_file_d;
        running_offset_q <= running_offset_d;
        started_q        <= (s1_mode_q == plgve_pkg::MODE_ENTRY);
      end else if (cfg_wr && !started_q) begin
        running_offset_q <= plgve_pkg::OffsetBits'(pwdata);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_count_o  = res_q.byte_count;
  assign first_byte_o  = res_q.first_byte;
  assign second_byte_o = res_q.second_byte;
  assign fill_valid_o  = res_q.fill_valid;
  assign fill_first_o  = res_q.fill_first;
  assign fill_last_o   = res_q.fill_last;
  assign fill_offset_o = res_q.fill_offset;

  // Checks
  `PLGVE_ASSERT_IMP(a_finish_fill, out_valid_q && (res_q.byte_count == plgve_pkg::COUNT_NONE), res_q.fill_valid && (res_q.fill_last == (25'd1 << TrigramBits)), "finish word without full table range")
  `PLGVE_ASSERT_IMP(a_two_byte_cont, out_valid_q && (res_q.byte_count == plgve_pkg::COUNT_TWO), res_q.first_byte[7], "two-byte varint lacks continuation bit")
  `PLGVE_ASSERT_IMP(a_fill_order, out_valid_q && res_q.fill_valid && (res_q.byte_count != plgve_pkg::COUNT_NONE), res_q.fill_first <= res_q.fill_last, "fill range reversed")
  `PLGVE_ASSERT_NXT(a_finish_restart, s1_adv && (s1_mode_q == plgve_pkg::MODE_FINISH), (running_offset_q == plgve_pkg::OffsetBits'($past(base_offset_q))) && !started_q, "finish did not restore offset")

endmodule
